[design/gfec_pkg.sv]
// Shared types, codes and defaults of the GF(2^m) erasure-code combiner.
package gfec_pkg;

  localparam int DEF_BLOCK_LEN   = 4096;
  localparam int DEF_MAX_BLOCKS  = 6;
  localparam int DEF_SYMBOL_BITS = 16;

  localparam int POS_W      = 12;
  localparam int SYM_W      = 16;
  localparam int ROW_W      = 3;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 16;

  localparam logic [SYM_W-1:0] POLY_RESET  = 16'h100B;
  localparam logic [ROW_W-1:0] COUNT_RESET = 3'd4;
  localparam logic [SYM_W-1:0] COEF_RESET  = 16'h0001;

  typedef enum logic {
    OP_ACCUM  = 1'b0,
    OP_UPDATE = 1'b1
  } op_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_POLY        = 3'd0,
    CFG_BLOCK_COUNT = 3'd1,
    CFG_COEF0       = 3'd2,
    CFG_COEF1       = 3'd3,
    CFG_COEF2       = 3'd4,
    CFG_COEF3       = 3'd5,
    CFG_COEF4       = 3'd6,
    CFG_COEF5       = 3'd7
  } cfg_reg_t;

  typedef struct packed {
    op_t              op;
    logic [ROW_W-1:0] block;
    logic [POS_W-1:0] position;
    logic [SYM_W-1:0] symbol;
    logic [SYM_W-1:0] old_symbol;
  } in_word_t;

  typedef struct packed {
    logic [POS_W-1:0] out_position;
    logic [SYM_W-1:0] value;
    logic             from_update;
  } out_word_t;

  // Settings seen by the datapath: polynomial and the clamped row count.
  typedef struct packed {
    logic [SYM_W-1:0] poly;
    logic [ROW_W-1:0] count;
  } cfg_state_t;

endpackage

[design/gf_erasure_code_combiner.sv]
// Top level of the GF(2^m) erasure-code combiner: pipeline, forwarding and handshake.
//
// Usage: each input word carries one symbol of one source row at one position.
// The symbol is multiplied in the field by that row's coefficient; row 0
// starts the result entry at the position, later rows XOR into it, and the
// last row (block_count - 1) sends the finished entry out. An update word
// XORs in coef * (symbol ^ old_symbol) and always sends the entry out.
// Words with a row at or above the block count, or a position at or above
// BLOCK_LEN, are dropped without effect.
// Channels: in_valid/in_stall/in_data and out_valid/out_stall/out_data; a word
// moves at a clock edge with valid high and stall low. Configuration is a
// plain write port (cfg_we, cfg_index, cfg_wdata), to be used only while idle; the block does not enforce it.
// Throughput is one word per cycle while the pipeline is not frozen. An accepted
// word passes through registers s1, s2 and s3 to the output register, a path that
// covers both halves of the field multiplier and the buffer read-modify-write.
// Entries written by the two words ahead are forwarded around the registered read.
// When the output register holds a word and out_stall is high, the whole
// pipeline freezes and in_stall follows. Reset clears the settings and the
// pipeline valid bits; the buffer holds no reset value, so row 0 must write
// a position before other rows or updates use it.
module gf_erasure_code_combiner import gfec_pkg::*; #(
  parameter int BLOCK_LEN   = DEF_BLOCK_LEN,
  parameter int MAX_BLOCKS  = DEF_MAX_BLOCKS,
  parameter int SYMBOL_BITS = DEF_SYMBOL_BITS,
  localparam int AW         = $clog2(BLOCK_LEN)
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  in_word_t              in_data,
  output logic                  out_valid,
  input  logic                  out_stall,
  output out_word_t             out_data,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_wdata
);

  cfg_state_t       cfg;
  logic [SYM_W-1:0] coef_sel;

  logic advance, accept, item_ok;

  // Stage 1: accepted word, first multiplier half works on its operands.
  logic                   s1_valid_r, s1_init_r, s1_emit_r;
  op_t                    s1_op_r;
  logic [POS_W-1:0]       s1_pos_r;
  logic [SYMBOL_BITS-1:0] s1_coef_r, s1_opnd_r;

  // Stage 2: buffer data arrives, forwarding picks the current entry.
  logic                   s2_valid_r, s2_init_r, s2_emit_r;
  op_t                    s2_op_r;
  logic [POS_W-1:0]       s2_pos_r;
  logic [SYMBOL_BITS-1:0] entry_nxt;

  // Stage 3: combine, write back and hand to the output register.
  logic                   s3_valid_r, s3_init_r, s3_emit_r;
  op_t                    s3_op_r;
  logic [POS_W-1:0]       s3_pos_r;
  logic [SYMBOL_BITS-1:0] s3_entry_r, s3_v;

  // Last write taken by the buffer, for the word whose read raced it.
  logic                   lw_valid_r;
  logic [POS_W-1:0]       lw_pos_r;
  logic [SYMBOL_BITS-1:0] lw_data_r;

  logic [SYMBOL_BITS-1:0] prod, rd_data;
  logic                   buf_we;

  logic      out_valid_r;
  out_word_t out_data_r;

  gfec_cfg #(
    .MAX_BLOCKS (MAX_BLOCKS)
  ) u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .row       (in_data.block),
    .coef      (coef_sel),
    .cfg       (cfg)
  );

  // The pipeline moves as one; it holds only while a result waits on a stall.
  assign advance  = !out_valid_r || !out_stall;
  assign in_stall = !advance;
  assign accept   = in_valid && advance;
  assign item_ok  = (in_data.block < cfg.count) &&
                    (32'(in_data.position) < 32'(BLOCK_LEN));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (advance) begin
      s1_valid_r <= accept && item_ok;
    end
  end

  // By linearity, coef*new ^ coef*old is coef*(new ^ old): one multiply per word.
  always_ff @(posedge clk) begin
    if (accept) begin
      s1_op_r   <= in_data.op;
      s1_init_r <= (in_data.op == OP_ACCUM) && (in_data.block == '0);
      s1_emit_r <= (in_data.op == OP_UPDATE) ||
                   (in_data.block == cfg.count - ROW_W'(1));
      s1_pos_r  <= in_data.position;
      s1_coef_r <= SYMBOL_BITS'(coef_sel);
      s1_opnd_r <= (in_data.op == OP_UPDATE) ?
                   SYMBOL_BITS'(in_data.symbol ^ in_data.old_symbol) :
                   SYMBOL_BITS'(in_data.symbol);
    end
  end

  gfec_gf_mul #(
    .SYMBOL_BITS (SYMBOL_BITS)
  ) u_mul (
    .clk  (clk),
    .en   (advance),
    .poly (SYMBOL_BITS'(cfg.poly)),
    .a    (s1_coef_r),
    .b    (s1_opnd_r),
    .prod (prod)
  );

  gfec_buf #(
    .DEPTH (BLOCK_LEN),
    .W     (SYMBOL_BITS)
  ) u_buf (
    .clk   (clk),
    .re    (advance && s1_valid_r),
    .raddr (AW'(s1_pos_r)),
    .rdata (rd_data),
    .we    (buf_we),
    .waddr (AW'(s3_pos_r)),
    .wdata (s3_v)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_valid_r <= 1'b0;
    end else if (advance) begin
      s2_valid_r <= s1_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      s2_op_r   <= s1_op_r;
      s2_init_r <= s1_init_r;
      s2_emit_r <= s1_emit_r;
      s2_pos_r  <= s1_pos_r;
    end
  end

  // The word one ahead (in stage 3) is newest; the one written at the read
  // edge comes next; otherwise the buffer data is current.
  always_comb begin
    priority if (s3_valid_r && (s3_pos_r == s2_pos_r)) begin
      entry_nxt = s3_v;
    end else if (lw_valid_r && (lw_pos_r == s2_pos_r)) begin
      entry_nxt = lw_data_r;
    end else begin
      entry_nxt = rd_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s3_valid_r <= 1'b0;
    end else if (advance) begin
      s3_valid_r <= s2_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      s3_op_r    <= s2_op_r;
      s3_init_r  <= s2_init_r;
      s3_emit_r  <= s2_emit_r;
      s3_pos_r   <= s2_pos_r;
      s3_entry_r <= entry_nxt;
    end
  end

  // Row 0 starts a fresh entry and ignores whatever the buffer held.
  assign s3_v   = (s3_init_r ? '0 : s3_entry_r) ^ prod;
  assign buf_we = advance && s3_valid_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      lw_valid_r <= 1'b0;
    end else if (advance) begin
      lw_valid_r <= s3_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      lw_pos_r  <= s3_pos_r;
      lw_data_r <= s3_v;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (advance) begin
      out_valid_r <= s3_valid_r && s3_emit_r;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_data_r.out_position <= s3_pos_r;
      out_data_r.value        <= SYM_W'(s3_v);
      out_data_r.from_update  <= (s3_op_r == OP_UPDATE);
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

`ifndef SYNTH
  a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> (out_valid && out_stall))
    else $error("input stalled without a waiting result");

  a_write_moves: assert property (@(posedge clk) disable iff (!rst_n)
    buf_we |-> !in_stall)
    else $error("buffer written while the pipeline is frozen");

  a_update_tag: assert property (@(posedge clk) disable iff (!rst_n)
    (advance && s3_valid_r && (s3_op_r == OP_UPDATE)) |=>
      (out_valid && out_data.from_update))
    else $error("update word did not produce a tagged result");

  a_result_source: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> $past(s3_valid_r && s3_emit_r))
    else $error("result appeared without an emitting word in stage 3");
`endif

endmodule

[design/gfec_cfg.sv]
// Configuration registers and per-row coefficient selection.
module gfec_cfg import gfec_pkg::*; #(
  parameter int MAX_BLOCKS = DEF_MAX_BLOCKS
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_wdata,
  input  logic [ROW_W-1:0]      row,
  output logic [SYM_W-1:0]      coef,
  output cfg_state_t            cfg
);

  logic [SYM_W-1:0] poly_r;
  logic [ROW_W-1:0] count_r;
  logic [SYM_W-1:0] coef_r [MAX_BLOCKS];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      poly_r  <= POLY_RESET;
      count_r <= COUNT_RESET;
      for (int i = 0; i < MAX_BLOCKS; i++) begin
        coef_r[i] <= COEF_RESET;
      end
    end else if (cfg_we) begin
      unique case (cfg_reg_t'(cfg_index))
        CFG_POLY:        poly_r  <= cfg_wdata[SYM_W-1:0];
        CFG_BLOCK_COUNT: count_r <= cfg_wdata[ROW_W-1:0];
        CFG_COEF0, CFG_COEF1, CFG_COEF2,
        CFG_COEF3, CFG_COEF4, CFG_COEF5: begin
          // Rows beyond MAX_BLOCKS can never be selected, so they have no storage.
          for (int i = 0; i < MAX_BLOCKS; i++) begin
            if (cfg_index == CFG_IDX_W'(int'(CFG_COEF0) + i)) begin
              coef_r[i] <= cfg_wdata[SYM_W-1:0];
            end
          end
        end
      endcase
    end
  end

  always_comb begin
    coef = '0;
    for (int i = 0; i < MAX_BLOCKS; i++) begin
      if (row == ROW_W'(i)) begin
        coef = coef_r[i];
      end
    end
  end

  // A count of zero means one row; counts above MAX_BLOCKS saturate.
  always_comb begin
    cfg.poly = poly_r;
    if (count_r == '0) begin
      cfg.count = ROW_W'(1);
    end else if (count_r > ROW_W'(MAX_BLOCKS)) begin
      cfg.count = ROW_W'(MAX_BLOCKS);
    end else begin
      cfg.count = count_r;
    end
  end

endmodule

[design/gfec_gf_mul.sv]
// Two-stage pipelined GF(2^m) multiplier with a programmable reduction polynomial.
module gfec_gf_mul import gfec_pkg::*; #(
  parameter int SYMBOL_BITS = DEF_SYMBOL_BITS
) (
  input  logic                   clk,
  input  logic                   en,
  input  logic [SYMBOL_BITS-1:0] poly,
  input  logic [SYMBOL_BITS-1:0] a,
  input  logic [SYMBOL_BITS-1:0] b,
  output logic [SYMBOL_BITS-1:0] prod
);

  localparam int LO = SYMBOL_BITS / 2;
  localparam int HI = SYMBOL_BITS - LO;

  logic [SYMBOL_BITS-1:0] acc_a, sh_a;
  logic [SYMBOL_BITS-1:0] acc_b, sh_b;
  logic [SYMBOL_BITS-1:0] acc_r, sh_r;
  logic [HI-1:0]          bhi_r;
  logic [SYMBOL_BITS-1:0] prod_r;

  // First half: multiplier bits below LO, shifting a by x each step.
  always_comb begin
    acc_a = '0;
    sh_a  = a;
    for (int i = 0; i < LO; i++) begin
      if (b[i]) begin
        acc_a = acc_a ^ sh_a;
      end
      sh_a = {sh_a[SYMBOL_BITS-2:0], 1'b0} ^ (sh_a[SYMBOL_BITS-1] ? poly : '0);
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      acc_r <= acc_a;
      sh_r  <= sh_a;
      bhi_r <= b[SYMBOL_BITS-1:LO];
    end
  end

  // Second half: remaining multiplier bits.
  always_comb begin
    acc_b = acc_r;
    sh_b  = sh_r;
    for (int i = 0; i < HI; i++) begin
      if (bhi_r[i]) begin
        acc_b = acc_b ^ sh_b;
      end
      sh_b = {sh_b[SYMBOL_BITS-2:0], 1'b0} ^ (sh_b[SYMBOL_BITS-1] ? poly : '0);
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      prod_r <= acc_b;
    end
  end

  assign prod = prod_r;

endmodule

[design/gfec_buf.sv]
// Result buffer: single-port-write, registered-read synchronous memory.
module gfec_buf import gfec_pkg::*; #(
  parameter int DEPTH = DEF_BLOCK_LEN,
  parameter int W     = DEF_SYMBOL_BITS,
  localparam int AW   = $clog2(DEPTH)
) (
  input  logic          clk,
  input  logic          re,
  input  logic [AW-1:0] raddr,
  output logic [W-1:0]  rdata,
  input  logic          we,
  input  logic [AW-1:0] waddr,
  input  logic [W-1:0]  wdata
);

  logic [W-1:0] mem [DEPTH];
  logic [W-1:0] rdata_r;

  // A read and a write to the same entry in one cycle return the old data.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule
